FILE: rtl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg: shared types and constants of the stack machine execute unit
// Opcodes, status codes, stack sizing, cell shift modes and channel payloads.
// ----------------------------------------------------------------------------
package smeu_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;

	// opcodes
	localparam logic [3:0] OP_HALT  = 4'd0;
	localparam logic [3:0] OP_PUSH  = 4'd1;
	localparam logic [3:0] OP_ADD   = 4'd2;
	localparam logic [3:0] OP_SUB   = 4'd3;
	localparam logic [3:0] OP_MUL   = 4'd4;
	localparam logic [3:0] OP_DIV   = 4'd5;
	localparam logic [3:0] OP_POP   = 4'd6;
	localparam logic [3:0] OP_RPUSH = 4'd7;
	localparam logic [3:0] OP_OUT   = 4'd8;
	localparam logic [3:0] OP_IN    = 4'd9;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNDER   = 3'd1;
	localparam logic [2:0] ST_OVER    = 3'd2;
	localparam logic [2:0] ST_DIVZERO = 3'd3;
	localparam logic [2:0] ST_HALTED  = 3'd4;

	// stack cell shift modes
	typedef logic [1:0] cell_mode_t;
	localparam cell_mode_t CELL_HOLD = 2'd0;
	localparam cell_mode_t CELL_PREV = 2'd1; // take from the cell above (toward top)
	localparam cell_mode_t CELL_NEXT = 2'd2; // take from the cell below

	typedef struct packed {
		logic [3:0]               kind;
		logic signed [DATA_W-1:0] value;
		logic [1:0]               reg_index;
	} item_t;

	typedef struct packed {
		logic                     out_valid;
		logic signed [DATA_W-1:0] out_value;
		logic [2:0]               status;
		logic                     is_halted;
	} result_t;

endpackage

FILE: rtl/smeu_cell.sv
// ----------------------------------------------------------------------------
// smeu_cell: one operand stack entry
// Holds a word, or shifts in the word of its upper or lower neighbor.
// ----------------------------------------------------------------------------
module smeu_cell (
	input  logic                             clk,
	input  smeu_pkg::cell_mode_t             mode,
	input  logic [smeu_pkg::DATA_W-1:0]      prev_d,
	input  logic [smeu_pkg::DATA_W-1:0]      next_d,
	output logic [smeu_pkg::DATA_W-1:0]      q
);

	logic [smeu_pkg::DATA_W-1:0] word_q;

	always_ff @(posedge clk) begin
		case (mode)
			smeu_pkg::CELL_PREV: word_q <= prev_d;
			smeu_pkg::CELL_NEXT: word_q <= next_d;
			default:             word_q <= word_q;
		endcase
	end

	assign q = word_q;

endmodule

FILE: rtl/smeu_div.sv
// ----------------------------------------------------------------------------
// smeu_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module smeu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [smeu_pkg::DATA_W-1:0] dividend,
	input  logic [smeu_pkg::DATA_W-1:0] divisor,
	output logic                        done,
	output logic [smeu_pkg::DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(smeu_pkg::DATA_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(smeu_pkg::DATA_W - 1);

	logic                        busy_q;
	logic                        fin_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        neg_q;
	logic [smeu_pkg::DATA_W-1:0] quo_q;
	logic [smeu_pkg::DATA_W-1:0] rem_q;
	logic [smeu_pkg::DATA_W-1:0] dvs_q;
	logic [smeu_pkg::DATA_W+1:0] trial;
	logic                        borrow;
	logic [smeu_pkg::DATA_W-1:0] abs_a;
	logic [smeu_pkg::DATA_W-1:0] abs_b;

	assign abs_a  = dividend[smeu_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign abs_b  = divisor[smeu_pkg::DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
	assign trial  = {1'b0, rem_q, quo_q[smeu_pkg::DATA_W-1]} - {2'b00, dvs_q};
	assign borrow = trial[smeu_pkg::DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= abs_a;
			dvs_q <= abs_b;
			rem_q <= '0;
			neg_q <= dividend[smeu_pkg::DATA_W-1] ^ divisor[smeu_pkg::DATA_W-1];
		end else if (busy_q) begin
			// remainder stays below the divisor magnitude, so its top bit is zero
			rem_q <= borrow ? {rem_q[smeu_pkg::DATA_W-2:0], quo_q[smeu_pkg::DATA_W-1]}
			                : trial[smeu_pkg::DATA_W-1:0];
			quo_q <= {quo_q[smeu_pkg::DATA_W-2:0], ~borrow};
		end
	end

	assign done     = fin_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

FILE: rtl/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit: stack machine instruction executor
// Runs one instruction per item on a shifting operand stack and four registers.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (item_valid / item_stall / item): one instruction per
//    transfer. item_stall is high while an instruction is in flight.
//  - result channel (result_valid / result_stall / result): exactly one
//    result per instruction, in order, held in an output register.
//  - The operand stack is a row of shift cells, top of stack in cell 0.
//    Push shifts the row down, pop shifts it up, a binary op writes cell 0
//    and shifts the rest up. Everything updates in the commit cycle.
//  - Steps: accept, then execute and commit; mul commits in S_MULW from
//    the registered product, a div that reaches the divider commits in
//    S_DIVW once the one-bit-per-cycle divide loop is done.
//  - A finished result waits in the output register while result_stall is
//    high; the next instruction is accepted meanwhile, but it commits only
//    once that register is free, so nothing is lost or overwritten.
//  - Reset (arst_n low) empties the stack, zeroes the registers and clears
//    the halted flag. Stack words themselves are not cleared.
//  - After halt every instruction returns status "already halted".
// ----------------------------------------------------------------------------
module stack_machine_execute_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  smeu_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output smeu_pkg::result_t result
);

	localparam int DW = smeu_pkg::DATA_W;
	localparam int SW = smeu_pkg::SP_W;
	localparam int ND = smeu_pkg::STACK_DEPTH;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_MULW = 2'd2;
	localparam logic [1:0] S_DIVW = 2'd3;

	logic [1:0]             state_q;
	logic [3:0]             kind_q;
	logic [DW-1:0]          value_q;
	logic [1:0]             ridx_q;
	logic [SW-1:0]          sp_q;
	logic                   halted_q;
	logic [DW-1:0]          gpr_q [4];
	logic [DW-1:0]          prod_q;
	logic                   res_valid_q;
	smeu_pkg::result_t      res_q;

	logic [DW-1:0]          cell_q [ND];
	smeu_pkg::cell_mode_t   cell_mode [ND];

	logic                   accept;
	logic                   out_free;
	logic                   commit;
	logic                   need_mul;
	logic                   need_div;
	logic                   div_start;
	logic                   div_done;
	logic [DW-1:0]          div_quo;
	logic [DW-1:0]          top_w;
	logic [DW-1:0]          left_w;
	logic                   has_one;
	logic                   has_two;
	logic                   is_full;
	logic                   is_binop;

	// commit decisions
	logic                   do_push;
	logic                   do_pop;
	logic                   do_bin;
	logic                   do_halt;
	logic                   do_rwr;
	logic [DW-1:0]          wr_data;
	smeu_pkg::result_t      res_d;

	assign top_w    = cell_q[0];
	assign left_w   = cell_q[1];
	assign has_one  = (sp_q != '0);
	assign has_two  = (sp_q > SW'(1));
	assign is_full  = (sp_q == SW'(ND));
	assign is_binop = (kind_q == smeu_pkg::OP_ADD) || (kind_q == smeu_pkg::OP_SUB) ||
	                  (kind_q == smeu_pkg::OP_MUL) || (kind_q == smeu_pkg::OP_DIV);

	assign accept   = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;
	assign need_mul = !halted_q && (kind_q == smeu_pkg::OP_MUL) && has_two;
	assign need_div = !halted_q && (kind_q == smeu_pkg::OP_DIV) && has_two && (top_w != '0);
	assign div_start = (state_q == S_EXEC) && need_div;
	assign commit   = out_free && (((state_q == S_EXEC) && !need_mul && !need_div) ||
	                               (state_q == S_MULW) ||
	                               ((state_q == S_DIVW) && div_done));

	// instruction outcome, valid whenever commit is high
	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		do_bin  = 1'b0;
		do_halt = 1'b0;
		do_rwr  = 1'b0;
		wr_data = value_q;
		res_d.out_valid = 1'b0;
		res_d.out_value = '0;
		res_d.status    = smeu_pkg::ST_OK;
		res_d.is_halted = halted_q;
		if (halted_q) begin
			res_d.status = smeu_pkg::ST_HALTED;
		end else begin
			case (kind_q)
				smeu_pkg::OP_HALT: begin
					do_halt = 1'b1;
					res_d.is_halted = 1'b1;
				end
				smeu_pkg::OP_PUSH, smeu_pkg::OP_RPUSH, smeu_pkg::OP_IN: begin
					wr_data = (kind_q == smeu_pkg::OP_RPUSH) ? gpr_q[ridx_q] : value_q;
					if (is_full) begin
						res_d.status = smeu_pkg::ST_OVER;
					end else begin
						do_push = 1'b1;
					end
				end
				smeu_pkg::OP_POP, smeu_pkg::OP_OUT: begin
					if (!has_one) begin
						res_d.status = smeu_pkg::ST_UNDER;
					end else begin
						do_pop = 1'b1;
						do_rwr = (kind_q == smeu_pkg::OP_POP);
						if (kind_q == smeu_pkg::OP_OUT) begin
							res_d.out_valid = 1'b1;
							res_d.out_value = top_w;
						end
					end
				end
				default: begin
					if (is_binop) begin
						case (kind_q)
							smeu_pkg::OP_ADD: wr_data = left_w + top_w;
							smeu_pkg::OP_SUB: wr_data = left_w - top_w;
							smeu_pkg::OP_MUL: wr_data = prod_q;
							default:          wr_data = div_quo;
						endcase
						if (!has_two) begin
							res_d.status = smeu_pkg::ST_UNDER;
						end else if ((kind_q == smeu_pkg::OP_DIV) && (top_w == '0)) begin
							res_d.status = smeu_pkg::ST_DIVZERO;
						end else begin
							do_bin = 1'b1;
						end
					end
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: begin
					if (need_mul)      state_q <= S_MULW;
					else if (need_div) state_q <= S_DIVW;
					else if (commit)   state_q <= S_IDLE;
				end
				S_MULW: if (commit) state_q <= S_IDLE;
				S_DIVW: if (commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_stall = (state_q != S_IDLE);

	// instruction register and product register
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= item.kind;
			value_q <= item.value;
			ridx_q  <= item.reg_index;
		end
		if (state_q == S_EXEC) begin
			prod_q <= left_w * top_w;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			halted_q <= 1'b0;
			for (int i = 0; i < 4; i++) gpr_q[i] <= '0;
		end else if (commit) begin
			if (do_halt) halted_q <= 1'b1;
			if (do_push) sp_q <= sp_q + 1'b1;
			if (do_pop || do_bin) sp_q <= sp_q - 1'b1;
			if (do_rwr) gpr_q[ridx_q] <= top_w;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) res_q <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// operand stack: row of shift cells, cell 0 is the top
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (commit && do_push) begin
				cell_mode[i] = smeu_pkg::CELL_PREV;
			end else if (commit && do_pop) begin
				cell_mode[i] = smeu_pkg::CELL_NEXT;
			end else if (commit && do_bin) begin
				cell_mode[i] = (i == 0) ? smeu_pkg::CELL_PREV : smeu_pkg::CELL_NEXT;
			end else begin
				cell_mode[i] = smeu_pkg::CELL_HOLD;
			end
		end
	end

	for (genvar g = 0; g < ND; g++) begin : g_cell
		logic [DW-1:0] prev_w;
		logic [DW-1:0] next_w;
		if (g == 0) begin : g_top
			assign prev_w = wr_data;
		end else begin : g_mid
			assign prev_w = cell_q[g-1];
		end
		if (g == ND - 1) begin : g_bot
			assign next_w = cell_q[g];
		end else begin : g_up
			assign next_w = cell_q[g+1];
		end
		smeu_cell u_cell (
			.clk    (clk),
			.mode   (cell_mode[g]),
			.prev_d (prev_w),
			.next_d (next_w),
			.q      (cell_q[g])
		);
	end

	smeu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (left_w),
		.divisor  (top_w),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule
